// ===== sv/open_addressing_hash_table_assert.svh =====
// Assertion macros for the open addressing hash table.
// Needs nothing else; included by files that assert.
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OAHT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define OAHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/oaht_pkg.sv =====
// Package for the open addressing hash table: codes, field widths, types.
// No dependencies.
`default_nettype none

package oaht_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_ID_W = 32;
   localparam int HASH_W   = 32;
   localparam int STORE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int LIMIT_W  = 8;
   localparam int COUNT_W  = 9;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd192;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [1:0]          slot_state_type;

   localparam op_type OP_GET    = 2'd0;
   localparam op_type OP_SET    = 2'd1;
   localparam op_type OP_REMOVE = 2'd2;

   localparam status_type STATUS_DONE   = 2'd0;
   localparam status_type STATUS_ABSENT = 2'd1;
   localparam status_type STATUS_FULL   = 2'd2;

   localparam slot_state_type SLOT_EMPTY = 2'd0;
   localparam slot_state_type SLOT_USED  = 2'd1;
   localparam slot_state_type SLOT_TOMB  = 2'd2;

endpackage

`default_nettype wire

// ===== sv/oaht_channels.sv =====
// Channel interfaces of the open addressing hash table: request, response, csr.
// Depends on oaht_pkg.
`default_nettype none

interface oaht_req_if;
   import oaht_pkg::*;
   logic                valid;
   logic                ready;
   op_type              op;
   logic [KEY_ID_W-1:0] key_id;
   logic [HASH_W-1:0]   key_hash;
   logic [STORE_W-1:0]  store_value;
   modport source (output valid, op, key_id, key_hash, store_value, input ready);
   modport sink   (input valid, op, key_id, key_hash, store_value, output ready);
endinterface

interface oaht_rsp_if;
   import oaht_pkg::*;
   logic               valid;
   logic               ready;
   status_type         status;
   logic [STORE_W-1:0] value_out;
   logic               new_key;
   modport source (output valid, status, value_out, new_key, input ready);
   modport sink   (input valid, status, value_out, new_key, output ready);
endinterface

interface oaht_csr_if;
   import oaht_pkg::*;
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/open_addressing_hash_table.sv =====
// Open addressing hash table, linear probing with tombstones (top level).
// Depends on oaht_pkg, oaht_channels.sv and open_addressing_hash_table_assert.svh.
//
// Usage:
//  - req_bus carries one request: op (get/set/remove), key_id, key_hash and
//    store_value. rsp_bus returns exactly one response per request: status,
//    value_out and new_key. csr_bus writes load_limit (taken every cycle).
//  - A request is taken only while no other is being probed. With P slots probed
//    (1 to TABLE_SLOTS, one per cycle on the single memory read port) the response
//    is registered when the probe stops, and the next request is taken only once
//    the table is back in idle.
//  - The response sits in an output register; a new request is accepted while
//    it waits. If a second response completes before the first is taken, it
//    parks in a hold register and the table stops taking requests until the
//    output register frees up.
//  - After reset the table sweeps its slot memory to empty, one slot per
//    cycle, and accepts no request until the sweep is done.
//    load_limit resets to 192 and the used count to zero.
//  - Table writes happen in the cycle the probe resolves, so the next request
//    always reads the updated contents; no forwarding is needed.
`default_nettype none

module open_addressing_hash_table #(
   parameter int TABLE_SLOTS = 256,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 64
) (
   input  wire          clock,
   input  wire          reset,
   oaht_req_if.sink     req_bus,
   oaht_rsp_if.source   rsp_bus,
   oaht_csr_if.sink     csr_bus
);
   import oaht_pkg::*;

   localparam int IDX_W    = $clog2(TABLE_SLOTS);
   localparam int KEY_KEEP = (KEY_BITS < KEY_ID_W) ? KEY_BITS : KEY_ID_W;
   localparam int KWORD_W  = KEY_BITS + 2;

   // controller states
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_HOLD  = 2'd3;

   // slot memories: {state, key} and value, one read port, one write port each
   logic [KWORD_W-1:0]    kmem [TABLE_SLOTS];
   logic [VALUE_BITS-1:0] vmem [TABLE_SLOTS];

   logic [KWORD_W-1:0]    krd_ff;
   logic [VALUE_BITS-1:0] vrd_ff;

   logic [1:0]            state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;        // slot under check / sweep address
   logic [IDX_W-1:0]      cnt_ff, cnt_in;        // slots probed so far
   logic                  tomb_seen_ff, tomb_seen_in;
   logic [IDX_W-1:0]      tomb_at_ff, tomb_at_in;
   logic [COUNT_W-1:0]    used_ff, used_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;

   // latched request
   op_type                op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;

   // output register and hold register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [STORE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                  rsp_newkey_ff, rsp_newkey_in;
   status_type            hold_status_ff;
   logic [STORE_W-1:0]    hold_value_ff;
   logic                  hold_newkey_ff;

   logic                  accept;
   logic                  out_free;
   logic [IDX_W-1:0]      rd_addr;

   // probe decode
   slot_state_type        slot_st;
   logic [KEY_BITS-1:0]   slot_key;
   logic                  hit_now, empty_now, last_now, done_now;
   logic                  tomb_any;
   logic [IDX_W-1:0]      tomb_idx;
   logic [COUNT_W:0]      used_next;
   logic                  room;

   // resolution
   logic                  kwe, vwe;
   logic [IDX_W-1:0]      kwaddr, vwaddr;
   logic [KWORD_W-1:0]    kwdata;
   logic                  used_inc;
   status_type            res_status;
   logic [STORE_W-1:0]    res_value;
   logic                  res_newkey;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.value_out = rsp_value_ff;
   assign rsp_bus.new_key   = rsp_newkey_ff;

   // Read address: home slot on accept, next slot while probing.
   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = req_bus.key_hash[IDX_W-1:0];
         S_CHECK: rd_addr = idx_ff + IDX_W'(1);
         default: rd_addr = idx_ff;
      endcase
   end

   // Look at the slot read last cycle.
   assign slot_st   = krd_ff[KWORD_W-1 -: 2];
   assign slot_key  = krd_ff[KEY_BITS-1:0];
   assign empty_now = (slot_st == SLOT_EMPTY);
   assign hit_now   = (slot_st == SLOT_USED) && (slot_key == key_ff);
   assign last_now  = (cnt_ff == {IDX_W{1'b1}});
   assign done_now  = empty_now || hit_now || last_now;
   // first tombstone on the run, this slot included
   assign tomb_any  = tomb_seen_ff || (slot_st == SLOT_TOMB);
   assign tomb_idx  = tomb_seen_ff ? tomb_at_ff : idx_ff;
   assign used_next = {1'b0, used_ff} + (COUNT_W+1)'(1);
   assign room      = (used_next <= (COUNT_W+1)'(limit_ff));

   // Resolve the request once the probe stops; clear each slot during the sweep.
   always_comb begin
      kwe        = 1'b0;
      vwe        = 1'b0;
      kwaddr     = idx_ff;
      vwaddr     = idx_ff;
      kwdata     = {SLOT_USED, key_ff};
      used_inc   = 1'b0;
      res_status = STATUS_DONE;
      res_value  = '0;
      res_newkey = 1'b0;
      if (state_ff == S_CLEAR) begin
         kwe    = 1'b1;
         kwdata = {SLOT_EMPTY, {KEY_BITS{1'b0}}};
      end else if (state_ff == S_CHECK && done_now) begin
         case (op_ff)
            OP_GET: begin
               if (hit_now) begin
                  res_value = STORE_W'(vrd_ff);
               end else begin
                  res_status = STATUS_ABSENT;
               end
            end
            OP_SET: begin
               if (hit_now) begin
                  vwe = 1'b1;
               end else if (tomb_any) begin
                  // reuse the first tombstone, count unchanged
                  res_newkey = 1'b1;
                  kwe        = 1'b1;
                  vwe        = 1'b1;
                  kwaddr     = tomb_idx;
                  vwaddr     = tomb_idx;
               end else if (empty_now && room) begin
                  res_newkey = 1'b1;
                  kwe        = 1'b1;
                  vwe        = 1'b1;
                  used_inc   = 1'b1;
               end else begin
                  res_newkey = 1'b1;
                  res_status = STATUS_FULL;
               end
            end
            OP_REMOVE: begin
               if (hit_now) begin
                  kwe    = 1'b1;
                  kwdata = {SLOT_TOMB, key_ff};
               end else begin
                  res_status = STATUS_ABSENT;
               end
            end
            default: begin
               // unused op: no change, plain done response
            end
         endcase
      end
   end

   // Next state of the controller and its counters.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      tomb_seen_in = tomb_seen_ff;
      tomb_at_in   = tomb_at_ff;
      used_in      = used_inc ? used_next[COUNT_W-1:0] : used_ff;
      limit_in     = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : limit_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_newkey_in = rsp_newkey_ff;

      case (state_ff)
         S_CLEAR: begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == {IDX_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in     = S_CHECK;
               idx_in       = req_bus.key_hash[IDX_W-1:0];
               cnt_in       = '0;
               tomb_seen_in = 1'b0;
            end
         end
         S_CHECK: begin
            if (done_now) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = res_status;
                  rsp_value_in  = res_value;
                  rsp_newkey_in = res_newkey;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_HOLD;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
               cnt_in = cnt_ff + IDX_W'(1);
               if (!tomb_seen_ff && slot_st == SLOT_TOMB) begin
                  tomb_seen_in = 1'b1;
                  tomb_at_in   = idx_ff;
               end
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = hold_status_ff;
               rsp_value_in  = hold_value_ff;
               rsp_newkey_in = hold_newkey_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Slot memories.
   always_ff @(posedge clock) begin
      if (kwe) begin
         kmem[kwaddr] <= kwdata;
      end
      if (vwe) begin
         vmem[vwaddr] <= val_ff;
      end
      krd_ff <= kmem[rd_addr];
      vrd_ff <= vmem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         tomb_seen_ff  <= 1'b0;
         used_ff       <= '0;
         limit_ff      <= LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         tomb_seen_ff  <= tomb_seen_in;
         used_ff       <= used_in;
         limit_ff      <= limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      tomb_at_ff    <= tomb_at_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_newkey_ff <= rsp_newkey_in;
      if (accept) begin
         op_ff  <= req_bus.op;
         key_ff <= KEY_BITS'(req_bus.key_id[KEY_KEEP-1:0]);
         val_ff <= VALUE_BITS'(req_bus.store_value);
      end
      if (state_ff == S_CHECK && done_now) begin
         hold_status_ff <= res_status;
         hold_value_ff  <= res_value;
         hold_newkey_ff <= res_newkey;
      end
   end

`include "open_addressing_hash_table_assert.svh"

   `OAHT_ASSERT_IMPLY(a_accept_idle, clock, reset, accept, state_ff == S_IDLE, "request taken outside idle")
   `OAHT_ASSERT_NEXT(a_accept_probe, clock, reset, accept, state_ff == S_CHECK, "probe did not start after request")
   `OAHT_ASSERT_IMPLY(a_write_state, clock, reset, kwe || vwe, state_ff == S_CHECK || state_ff == S_CLEAR, "table written outside probe or sweep")
   `OAHT_ASSERT_IMPLY(a_used_step, clock, reset, !$past(reset), used_ff == $past(used_ff) || used_ff == $past(used_ff) + COUNT_W'(1), "used count moved by more than one")
   `OAHT_ASSERT_IMPLY(a_hold_blocked, clock, reset, state_ff == S_HOLD, rsp_valid_ff, "hold state with empty output register")

endmodule

`default_nettype wire
